@@ rtl/core/iir4_pkg.sv @@
// Shared types, widths and reset constants for the fourth-order IIR filter core.
// No dependencies; every other file of the core uses this package.
`timescale 1ns / 1ps

package iir4_pkg;

  localparam int InW      = 16;
  localparam int OutW     = 20;
  localparam int CoefW    = 18;
  localparam int Fb34W    = 2 * CoefW;
  localparam int CfgW     = Fb34W;
  localparam int AddrW    = 3;
  localparam int Taps     = 4;
  localparam int FfProdW  = CoefW + InW;
  localparam int FbProdW  = CoefW + OutW;
  localparam int AccW     = 44;
  localparam int FracDrop = 17;
  localparam int FbShift  = 2;

  typedef logic signed [InW-1:0]   sample_t;
  typedef logic signed [OutW-1:0]  result_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [AccW-1:0]  acc_t;

  typedef enum logic [AddrW-1:0] {
    REG_FF_COEF0  = 3'd0,
    REG_FF_COEF1  = 3'd1,
    REG_FF_COEF2  = 3'd2,
    REG_FF_COEF3  = 3'd3,
    REG_FF_COEF4  = 3'd4,
    REG_FB_COEF1  = 3'd5,
    REG_FB_COEF2  = 3'd6,
    REG_FB_COEF34 = 3'd7
  } cfg_reg_t;

  localparam coef_t FfCoef0Rst = coef_t'(452);
  localparam coef_t FfCoef1Rst = coef_t'(1810);
  localparam coef_t FfCoef2Rst = coef_t'(2716);
  localparam coef_t FfCoef3Rst = coef_t'(1810);
  localparam coef_t FfCoef4Rst = coef_t'(452);
  localparam coef_t FbCoef1Rst = coef_t'(-82558);
  localparam coef_t FbCoef2Rst = coef_t'(83913);
  localparam logic [Fb34W-1:0] FbCoef34Rst = 36'd1891067290;

  localparam acc_t OutMax  = acc_t'((64'sd1 <<< (OutW - 1)) - 64'sd1);
  localparam acc_t OutMin  = acc_t'(-(64'sd1 <<< (OutW - 1)));
  localparam acc_t RndBias = acc_t'(64'sd1 <<< (FracDrop - 1));

endpackage

@@ rtl/core/iir4_in_if.sv @@
// Input sample channel of the IIR filter core: valid, ready and one sample.
// Depends on iir4_pkg for the sample width.
`timescale 1ns / 1ps

interface iir4_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [iir4_pkg::InW-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

@@ rtl/core/iir4_out_if.sv @@
// Output sample channel of the IIR filter core: valid, ready and one result.
// Depends on iir4_pkg for the result width.
`timescale 1ns / 1ps

interface iir4_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [iir4_pkg::OutW-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

@@ rtl/core/iir_filter_order4_core.sv @@
// Accepted samples are registered in s1_sample, their results in out_sample for dout.
// Throughput: one sample per cycle unless dout stalls; the feedback path from the output
// history through nine parallel multipliers, the sum, rounding and saturation closes
// combinationally. Reset (synchronous, active high) clears both histories and both valid
// flags and loads the default coefficients. Depends on iir4_pkg, iir4_in_if, iir4_out_if.
`timescale 1ns / 1ps

module iir_filter_order4_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [iir4_pkg::AddrW-1:0]   cfg_addr,
  input  logic [iir4_pkg::CfgW-1:0]    cfg_data,
  iir4_in_if.sink                      din,
  iir4_out_if.source                   dout
);
  import iir4_pkg::*;

  coef_t              ff_coef [Taps+1];
  coef_t              fb_coef12 [2];
  logic [Fb34W-1:0]   fb_coef34;
  coef_t              fb_coef [Taps];

  sample_t            x_hist [Taps];
  result_t            y_hist [Taps];

  logic               s1_valid;
  sample_t            s1_sample;
  logic               out_valid;
  result_t            out_sample;
  logic               advance;

  logic signed [FfProdW-1:0] ff_prod [Taps+1];
  logic signed [FbProdW-1:0] fb_prod [Taps];
  acc_t               acc;
  acc_t               acc_shift;
  result_t            y_next;

  assign fb_coef[0] = fb_coef12[0];
  assign fb_coef[1] = fb_coef12[1];
  assign fb_coef[2] = fb_coef34[CoefW-1:0];
  assign fb_coef[3] = fb_coef34[Fb34W-1:CoefW];

  assign advance     = s1_valid && (!out_valid || dout.ready);
  assign din.ready   = !s1_valid || advance;
  assign dout.valid  = out_valid;
  assign dout.sample_out = out_sample;

  always_comb begin
    ff_prod[0] = FfProdW'(ff_coef[0]) * FfProdW'(s1_sample);
    for (int i = 0; i < Taps; i++) begin
      ff_prod[i+1] = FfProdW'(ff_coef[i+1]) * FfProdW'(x_hist[i]);
      fb_prod[i]   = FbProdW'(fb_coef[i]) * FbProdW'(y_hist[i]);
    end
    acc = acc_t'(ff_prod[0]);
    for (int i = 0; i < Taps; i++) begin
      acc = acc + acc_t'(ff_prod[i+1]) - (acc_t'(fb_prod[i]) <<< FbShift);
    end
    acc_shift = (acc + RndBias) >>> FracDrop;
    if (acc_shift > OutMax) begin
      y_next = OutMax[OutW-1:0];
    end else if (acc_shift < OutMin) begin
      y_next = OutMin[OutW-1:0];
    end else begin
      y_next = acc_shift[OutW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      ff_coef[0]   <= FfCoef0Rst;
      ff_coef[1]   <= FfCoef1Rst;
      ff_coef[2]   <= FfCoef2Rst;
      ff_coef[3]   <= FfCoef3Rst;
      ff_coef[4]   <= FfCoef4Rst;
      fb_coef12[0] <= FbCoef1Rst;
      fb_coef12[1] <= FbCoef2Rst;
      fb_coef34    <= FbCoef34Rst;
      for (int i = 0; i < Taps; i++) begin
        x_hist[i] <= '0;
        y_hist[i] <= '0;
      end
    end else begin
      if (din.valid && din.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
        x_hist[0] <= s1_sample;
        y_hist[0] <= y_next;
        for (int i = 1; i < Taps; i++) begin
          x_hist[i] <= x_hist[i-1];
          y_hist[i] <= y_hist[i-1];
        end
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_FF_COEF0:  ff_coef[0]   <= cfg_data[CoefW-1:0];
          REG_FF_COEF1:  ff_coef[1]   <= cfg_data[CoefW-1:0];
          REG_FF_COEF2:  ff_coef[2]   <= cfg_data[CoefW-1:0];
          REG_FF_COEF3:  ff_coef[3]   <= cfg_data[CoefW-1:0];
          REG_FF_COEF4:  ff_coef[4]   <= cfg_data[CoefW-1:0];
          REG_FB_COEF1:  fb_coef12[0] <= cfg_data[CoefW-1:0];
          REG_FB_COEF2:  fb_coef12[1] <= cfg_data[CoefW-1:0];
          REG_FB_COEF34: fb_coef34    <= cfg_data[Fb34W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s1_sample <= din.sample_in;
    end
    if (advance) begin
      out_sample <= y_next;
    end
  end

endmodule

@@ rtl/core/iir4_checker.sv @@
// Port-level checks for iir_filter_order4_core, attached by the bind below.
// Depends on iir4_pkg and on the top level's channel ports.
`timescale 1ns / 1ps

module iir4_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [iir4_pkg::OutW-1:0]  out_sample
);
  import iir4_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid right after reset.");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("Input stalled although the output side takes a beat.");

  a_beat_reaches_output: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> ##1 out_valid)
    else $error("Accepted beat did not reach the output register.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("Stalled output beat changed or dropped.");

endmodule

bind iir_filter_order4_core iir4_checker u_iir4_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .out_sample (dout.sample_out)
);

@@ dv/iir_filter_order4_core_test.sv @@
// Self-checking testbench for the fourth-order IIR filter core: random beats with idle
// gaps and output stalls, several coefficient settings, and a built-in filter predictor.
// Depends on iir4_pkg, iir4_in_if, iir4_out_if and iir_filter_order4_core.
`timescale 1ns / 1ps

module iir_filter_order4_core_test;
  import iir4_pkg::*;

  localparam int QuietLimit = 2000;
  localparam coef_t CoefMax = {1'b0, {(CoefW - 1){1'b1}}};
  localparam coef_t CoefMin = {1'b1, {(CoefW - 1){1'b0}}};
  localparam sample_t SampleMax = {1'b0, {(InW - 1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(InW - 1){1'b0}}};
  localparam int SideSource = 0;
  localparam int SideSink = 1;
  localparam int SetDefault = 0;
  localparam int SetRandom = 1;
  localparam int SetMild = 2;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [AddrW-1:0] cfg_addr;
  logic [CfgW-1:0] cfg_data;

  iir4_in_if din ();
  iir4_out_if dout ();

  iir_filter_order4_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .din(din),
    .dout(dout)
  );

  coef_t ff_b [5];
  coef_t fb_a [4];
  sample_t x_past [4];
  result_t y_past [4];

  sample_t samples_to_send [$];
  result_t outputs_due [$];
  int mismatches = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int calm_left [2] = '{0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t iir_next_output(sample_t x);
    longint acc;
    longint y;
    longint y_max;
    longint y_min;
    y_max = (longint'(1) <<< (OutW - 1)) - 1;
    y_min = -(longint'(1) <<< (OutW - 1));
    acc = longint'(ff_b[0]) * longint'(x);
    for (int k = 0; k < Taps; k++) begin
      acc += longint'(ff_b[k + 1]) * longint'(x_past[k]);
      acc -= (longint'(fb_a[k]) * longint'(y_past[k])) <<< FbShift;
    end
    y = (acc + (longint'(1) <<< (FracDrop - 1))) >>> FracDrop;
    if (y > y_max) y = y_max;
    if (y < y_min) y = y_min;
    for (int k = Taps - 1; k > 0; k--) begin
      x_past[k] = x_past[k - 1];
      y_past[k] = y_past[k - 1];
    end
    x_past[0] = x;
    y_past[0] = result_t'(y);
    return result_t'(y);
  endfunction

  function automatic int draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return SampleMax;
      1: return SampleMin;
      2: return sample_t'($urandom_range(0, 1) ? 0 : -1);
      3, 4: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CfgW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    case (idx)
      REG_FB_COEF1: fb_a[0] = data[CoefW-1:0];
      REG_FB_COEF2: fb_a[1] = data[CoefW-1:0];
      REG_FB_COEF34: begin
        fb_a[2] = data[CoefW-1:0];
        fb_a[3] = data[Fb34W-1:CoefW];
      end
      default: ff_b[idx] = data[CoefW-1:0];
    endcase
  endtask

  // Unused upper data bits of the narrow registers carry random junk.
  task automatic set_filter(input coef_t b [5], input coef_t a [4]);
    write_reg(REG_FF_COEF0, {CoefW'($urandom), b[0]});
    write_reg(REG_FF_COEF1, {CoefW'($urandom), b[1]});
    write_reg(REG_FF_COEF2, {CoefW'($urandom), b[2]});
    write_reg(REG_FF_COEF3, {CoefW'($urandom), b[3]});
    write_reg(REG_FF_COEF4, {CoefW'($urandom), b[4]});
    write_reg(REG_FB_COEF1, {CoefW'($urandom), a[0]});
    write_reg(REG_FB_COEF2, {CoefW'($urandom), a[1]});
    write_reg(REG_FB_COEF34, {a[3], a[2]});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (samples_to_send.size() != 0 || din.valid || outputs_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send(sample_t x);
    samples_to_send.push_back(x);
  endtask

  always @(posedge clk) begin : source_drv
    int w;
    if (rst) begin
      din.valid <= 1'b0;
      din.sample_in <= '0;
      tx_wait <= 0;
    end else if (!din.valid || din.ready) begin
      w = din.valid ? draw_wait(SideSource) : tx_wait;
      if (w != 0) begin
        din.valid <= 1'b0;
        tx_wait <= w - 1;
      end else if (samples_to_send.size() != 0) begin
        din.valid <= 1'b1;
        din.sample_in <= samples_to_send.pop_front();
        tx_wait <= 0;
      end else begin
        din.valid <= 1'b0;
        tx_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin : sink_drv
    int w;
    if (rst) begin
      dout.ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = (dout.valid && dout.ready) ? draw_wait(SideSink) : rx_wait;
      if (w != 0) begin
        dout.ready <= 1'b0;
        rx_wait <= w - 1;
      end else begin
        dout.ready <= 1'b1;
        rx_wait <= 0;
      end
    end
  end

  // The output beat is checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (!rst) begin
      if (dout.valid && dout.ready) begin
        if (outputs_due.size() == 0) begin
          $display("%0t: sample_out mismatch: expected none, got %0d", $time,
                   dout.sample_out);
          mismatches++;
        end else begin
          want = outputs_due.pop_front();
          if (dout.sample_out !== want) begin
            $display("%0t: sample_out mismatch: expected %0d, got %0d", $time, want,
                     dout.sample_out);
            mismatches++;
          end
        end
      end
      if (din.valid && din.ready) outputs_due.push_back(iir_next_output(din.sample_in));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((din.valid && din.ready) || (dout.valid && dout.ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    coef_t b [5];
    coef_t a [4];
    coef_t b_rst [5];
    coef_t a_rst [4];
    int kind;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    din.valid = 1'b0;
    din.sample_in = '0;
    dout.ready = 1'b0;
    b_rst = '{FfCoef0Rst, FfCoef1Rst, FfCoef2Rst, FfCoef3Rst, FfCoef4Rst};
    a_rst = '{FbCoef1Rst, FbCoef2Rst, FbCoef34Rst[CoefW-1:0], FbCoef34Rst[Fb34W-1:CoefW]};
    ff_b = b_rst;
    fb_a = a_rst;
    for (int k = 0; k < Taps; k++) begin
      x_past[k] = '0;
      y_past[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset coefficients: impulse response and the input extremes.
    @(negedge clk);
    send(SampleMax);
    send(0);
    send(0);
    send(SampleMin);
    send(-1);
    send(1);
    send(SampleMax);
    wait_idle();

    // A pure gain of 4 on the current sample puts the sum exactly on rounding ties for 16384 and -16384.
    b = '{4, 0, 0, 0, 0};
    a = '{0, 0, 0, 0};
    set_filter(b, a);
    @(negedge clk);
    send(16384);
    send(-16384);
    send(16385);
    send(-16385);
    send(0);
    send(SampleMax);
    wait_idle();

    // Largest gains with unstable feedback drive the output into saturation.
    b = '{5{CoefMax}};
    a = '{4{CoefMin}};
    set_filter(b, a);
    @(negedge clk);
    repeat (3) send(SampleMax);
    repeat (3) send(SampleMin);
    wait_idle();

    b = '{5{CoefMin}};
    a = '{4{CoefMax}};
    set_filter(b, a);
    @(negedge clk);
    send(SampleMax);
    send(SampleMin);
    send(SampleMax);
    send(0);
    send(-1);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      kind = ph % 3;
      case (kind)
        SetDefault: begin
          b = b_rst;
          a = a_rst;
        end
        SetRandom: begin
          for (int k = 0; k < 5; k++) b[k] = coef_t'($urandom);
          for (int k = 0; k < 4; k++) a[k] = coef_t'($urandom);
        end
        SetMild: begin
          for (int k = 0; k < 5; k++) b[k] = coef_t'($urandom);
          for (int k = 0; k < 4; k++) a[k] = coef_t'(int'($urandom_range(0, 16384)) - 8192);
        end
        default: ;
      endcase
      set_filter(b, a);
      @(negedge clk);
      repeat (138) send(random_sample());
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
